>>> hw/rtl/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the CRC-8 byte update for the sensor frame
// receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hA5;
    localparam logic [7:0] HDR_SECOND = 8'h5A;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam logic signed [15:0] SAMPLE_MIN_RST = -16'sd1000;
    localparam logic signed [15:0] SAMPLE_MAX_RST = 16'sd26400;
    localparam logic [15:0]        STEP_LIMIT_RST = 16'd15000;

    // frame position codes; 2..6 are payload byte slots
    localparam logic [2:0] POS_HUNT = 3'd0;
    localparam logic [2:0] POS_HDR  = 3'd1;
    localparam logic [2:0] POS_SEQ  = 3'd2;
    localparam logic [2:0] POS_ALO  = 3'd3;
    localparam logic [2:0] POS_AHI  = 3'd4;
    localparam logic [2:0] POS_BLO  = 3'd5;
    localparam logic [2:0] POS_BHI  = 3'd6;
    localparam logic [2:0] POS_CRC  = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_MIN = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_MAX = 2'd1;
    localparam logic [1:0] CFG_STEP_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CRC   = 2'd1,
        ST_RANGE = 2'd2,
        ST_SLEW  = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [7:0]         seq;
        logic signed [15:0] accel;
        logic signed [15:0] brake;
    } result_t;

    // CRC-8, poly 07, MSB first, one byte
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/sensor_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_receiver
// Byte-serial receiver for 8-byte A5 5A sensor frames with CRC-8, range and
// slew checks.
// ----------------------------------------------------------------------------
// One input item per cycle while in_stall is low: a byte (op 0) or a
// link-lost notice (op 1). Each item is handled in the cycle it is accepted:
// header hunt, CRC-8 update and, on the eighth byte, the CRC, range and slew
// checks all resolve in one pass of logic into the result register, or into
// the skid buffer while the result register is held. A finished frame gives
// one result item; all other items give none. A one-entry skid buffer behind
// the result register lets input continue while a result is stalled;
// in_stall rises only when both are full.
module sensor_frame_receiver
    import sfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [7:0]         byte_value,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         sequence_res,
    output logic signed [15:0] accel_sample,
    output logic signed [15:0] brake_sample
);

    logic signed [15:0] sample_min_reg;
    logic signed [15:0] sample_max_reg;
    logic [15:0]        step_limit_reg;

    logic [2:0]         pos_reg, pos_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         fbytes_reg [5];
    logic signed [15:0] last_accel_reg, last_accel_next;
    logic signed [15:0] last_brake_reg, last_brake_next;
    logic               hist_valid_reg, hist_valid_next;

    result_t            out_reg, skid_reg;
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic               acc;
    logic               res_valid;
    result_t            res;
    logic [7:0]         crc_fed;
    logic [7:0]         crc_hdr;
    logic signed [15:0] a_s, k_s;
    logic               a_in, k_in;
    logic signed [16:0] a_diff, k_diff;
    logic [16:0]        a_abs, k_abs;
    logic               slew_bad;
    logic               out_take;

    assign acc      = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_min_reg <= SAMPLE_MIN_RST;
            sample_max_reg <= SAMPLE_MAX_RST;
            step_limit_reg <= STEP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_MIN: sample_min_reg <= cfg_data;
                CFG_SAMPLE_MAX: sample_max_reg <= cfg_data;
                CFG_STEP_LIMIT: step_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // frame checks
    assign crc_fed = crc_feed(crc_reg, byte_value);
    assign crc_hdr = crc_feed(8'h00, HDR_FIRST);

    assign a_s = {fbytes_reg[2], fbytes_reg[1]};
    assign k_s = {fbytes_reg[4], fbytes_reg[3]};

    assign a_in = (a_s >= sample_min_reg) && (a_s <= sample_max_reg);
    assign k_in = (k_s >= sample_min_reg) && (k_s <= sample_max_reg);

    assign a_diff = 17'(a_s) - 17'(last_accel_reg);
    assign k_diff = 17'(k_s) - 17'(last_brake_reg);
    assign a_abs  = a_diff[16] ? 17'(-a_diff) : 17'(a_diff);
    assign k_abs  = k_diff[16] ? 17'(-k_diff) : 17'(k_diff);
    assign slew_bad = (a_abs > {1'b0, step_limit_reg}) || (k_abs > {1'b0, step_limit_reg});

    always_comb
    begin
        res.seq   = fbytes_reg[0];
        res.accel = a_s;
        res.brake = k_s;
        priority if (crc_reg != byte_value)
            res.status = ST_CRC;
        else if (!a_in || !k_in)
            res.status = ST_RANGE;
        else if (hist_valid_reg && slew_bad)
            res.status = ST_SLEW;
        else
            res.status = ST_OK;
    end

    // frame assembly and history
    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        last_accel_next = last_accel_reg;
        last_brake_next = last_brake_reg;
        hist_valid_next = hist_valid_reg;
        res_valid       = 1'b0;
        if (acc)
        begin
            if (op)
            begin
                hist_valid_next = 1'b0;
            end
            else
            begin
                unique case (pos_reg)
                    POS_HUNT:
                    begin
                        if (byte_value == HDR_FIRST)
                        begin
                            crc_next = crc_hdr;
                            pos_next = POS_HDR;
                        end
                    end
                    POS_HDR:
                    begin
                        priority if (byte_value == HDR_SECOND)
                        begin
                            crc_next = crc_fed;
                            pos_next = POS_SEQ;
                        end
                        else if (byte_value == HDR_FIRST)
                        begin
                            // restart on a repeated first header byte
                            crc_next = crc_hdr;
                            pos_next = POS_HDR;
                        end
                        else
                        begin
                            crc_next = 8'h00;
                            pos_next = POS_HUNT;
                        end
                    end
                    POS_CRC:
                    begin
                        res_valid = 1'b1;
                        if (res.status == ST_OK)
                        begin
                            last_accel_next = a_s;
                            last_brake_next = k_s;
                            hist_valid_next = 1'b1;
                        end
                        crc_next = 8'h00;
                        pos_next = POS_HUNT;
                    end
                    default:
                    begin
                        crc_next = crc_fed;
                        pos_next = pos_reg + 3'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_HUNT;
            crc_reg        <= 8'h00;
            last_accel_reg <= '0;
            last_brake_reg <= '0;
            hist_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            last_accel_reg <= last_accel_next;
            last_brake_reg <= last_brake_next;
            hist_valid_reg <= hist_valid_next;
        end
    end

    // payload byte store
    always_ff @(posedge clk)
    begin
        if (acc && !op)
        begin
            unique case (pos_reg)
                POS_SEQ: fbytes_reg[0] <= byte_value;
                POS_ALO: fbytes_reg[1] <= byte_value;
                POS_AHI: fbytes_reg[2] <= byte_value;
                POS_BLO: fbytes_reg[3] <= byte_value;
                POS_BHI: fbytes_reg[4] <= byte_value;
                default: ;
            endcase
        end
    end

    // result register and skid buffer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_valid_next = 1'b1;
            else
                skid_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign sequence_res = out_reg.seq;
    assign accel_sample = out_reg.accel;
    assign brake_sample = out_reg.brake;

endmodule

>>> sim/sensor_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_receiver_tb
// Self-checking bench for the sensor frame receiver. A model tracks the
// header hunt, CRC-8, range window and slew history. It builds the expected
// frame results. A monitor compares every result field by field. The input
// is directed header, CRC and link-loss cases, then random frame traffic.
// The random traffic runs under several threshold settings, with random
// idles on both sides, a long result hold-off and a drain pause.
// ----------------------------------------------------------------------------
module sensor_frame_receiver_tb;
    import sfr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [7:0]         byte_value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [7:0]         sequence_res;
    logic signed [15:0] accel_sample;
    logic signed [15:0] brake_sample;

    // receiver model state
    logic signed [15:0] m_min;
    logic signed [15:0] m_max;
    logic [15:0]        m_step;
    logic [2:0]         m_pos;
    logic [7:0]         m_crc;
    logic [7:0]         m_bytes [5];
    logic signed [15:0] m_last_accel;
    logic signed [15:0] m_last_brake;
    logic               m_hist;

    result_t expected_frames [$];
    int      mismatch_count = 0;
    int      items_sent = 0;
    int      status_hits [4] = '{0, 0, 0, 0};
    int      hold_cycles = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;

    sensor_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .byte_value   (byte_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .sequence_res (sequence_res),
        .accel_sample (accel_sample),
        .brake_sample (brake_sample)
    );

    always #5 clk = ~clk;

    // CRC-8 poly 07, fed one data bit at a time, MSB first
    function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ d[i];
            c = {c[6:0], 1'b0};
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic bit in_window(input logic signed [15:0] s);
        return (s >= m_min) && (s <= m_max);
    endfunction

    function automatic bit step_fits(input logic signed [15:0] now, input logic signed [15:0] prev);
        logic signed [16:0] d;
        d = now - prev;
        if (d < 0)
            d = -d;
        return d <= $signed({1'b0, m_step});
    endfunction

    function automatic void rx_predict(input logic o, input logic [7:0] b);
        logic signed [15:0] a;
        logic signed [15:0] k;
        status_t            st;
        result_t            r;
        if (o)
        begin
            m_hist = 1'b0;
            return;
        end
        case (m_pos)
            POS_HUNT:
            begin
                if (b == HDR_FIRST)
                begin
                    m_crc = crc8_next(8'h00, b);
                    m_pos = POS_HDR;
                end
            end
            POS_HDR:
            begin
                if (b == HDR_SECOND)
                begin
                    m_crc = crc8_next(m_crc, b);
                    m_pos = POS_SEQ;
                end
                else if (b == HDR_FIRST)
                begin
                    // resync on a repeated first header byte
                    m_crc = crc8_next(8'h00, b);
                    m_pos = POS_HDR;
                end
                else
                begin
                    m_crc = 8'h00;
                    m_pos = POS_HUNT;
                end
            end
            POS_CRC:
            begin
                a = {m_bytes[2], m_bytes[1]};
                k = {m_bytes[4], m_bytes[3]};
                if (m_crc != b)
                    st = ST_CRC;
                else if (!in_window(a) || !in_window(k))
                    st = ST_RANGE;
                else if (m_hist && (!step_fits(a, m_last_accel) || !step_fits(k, m_last_brake)))
                    st = ST_SLEW;
                else
                    st = ST_OK;
                if (st == ST_OK)
                begin
                    m_last_accel = a;
                    m_last_brake = k;
                    m_hist = 1'b1;
                end
                r.status = st;
                r.seq = m_bytes[0];
                r.accel = a;
                r.brake = k;
                expected_frames.push_back(r);
                m_pos = POS_HUNT;
                m_crc = 8'h00;
            end
            default:
            begin
                m_bytes[m_pos - POS_SEQ] = b;
                m_crc = crc8_next(m_crc, b);
                m_pos = m_pos + 3'd1;
            end
        endcase
    endfunction

    task automatic send_item(input logic o, input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 20)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        op = o;
        byte_value = b;
        do
            @(posedge clk);
        while (in_stall);
        rx_predict(o, b);
        items_sent++;
    endtask

    // lost_at < 0: no link-lost item inside the frame
    task automatic send_frame(input logic [7:0] seq, input logic signed [15:0] a,
                              input logic signed [15:0] k, input bit bad_crc,
                              input int lost_at);
        logic [7:0] fb [8];
        fb[0] = HDR_FIRST;
        fb[1] = HDR_SECOND;
        fb[2] = seq;
        fb[3] = a[7:0];
        fb[4] = a[15:8];
        fb[5] = k[7:0];
        fb[6] = k[15:8];
        fb[7] = 8'h00;
        for (int i = 0; i < 7; i++)
            fb[7] = crc8_next(fb[7], fb[i]);
        if (bad_crc)
            fb[7] = fb[7] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < 8; i++)
        begin
            if (i == lost_at)
                send_item(1'b1, 8'($urandom));
            send_item(1'b0, fb[i]);
        end
    endtask

    // random, in-window, slew-limit and window-edge or extreme values
    function automatic logic signed [15:0] pick_sample(input logic signed [15:0] prev);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1:
            begin
                if (m_min <= m_max)
                    v = int'(m_min) + $urandom_range(0, int'(m_max) - int'(m_min));
                else
                    v = $urandom;
            end
            2: v = int'(prev) + ($urandom_range(0, 1) ? 1 : -1)
                   * (int'(m_step) + $urandom_range(0, 1));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = int'(m_min);
                    default: v = int'(m_max);
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    task automatic send_random_frame(input bit allow_faults);
        send_frame(8'($urandom_range(0, 255)), pick_sample(m_last_accel),
                   pick_sample(m_last_brake),
                   allow_faults && $urandom_range(0, 99) < 12,
                   (allow_faults && $urandom_range(0, 99) < 5) ? $urandom_range(1, 7) : -1);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        case (idx)
            CFG_SAMPLE_MIN: m_min = v;
            CFG_SAMPLE_MAX: m_max = v;
            CFG_STEP_LIMIT: m_step = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_thresholds(input logic [15:0] lo, input logic [15:0] hi,
                                  input logic [15:0] step);
        wait_drain();
        write_reg(CFG_SAMPLE_MIN, lo);
        write_reg(CFG_SAMPLE_MAX, hi);
        write_reg(CFG_STEP_LIMIT, step);
    endtask

    task automatic run_traffic(input int n);
        int stop_at;
        int r;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_random_frame(1'b1);
            else if (r < 78)
            begin
                // header start followed by a random second byte, sometimes A5
                send_item(1'b0, HDR_FIRST);
                send_item(1'b0, $urandom_range(0, 1) ? HDR_FIRST : 8'($urandom));
            end
            else if (r < 84)
            begin
                // truncated frame; the next bytes get absorbed as its payload
                send_item(1'b0, HDR_FIRST);
                send_item(1'b0, HDR_SECOND);
                repeat ($urandom_range(1, 5)) send_item(1'b0, 8'($urandom));
            end
            else if (r < 92)
                repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom));
            else
                send_item(1'b1, 8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'hFF);
        // A5 A5 5A ...: resync, then samples exactly on the window edges
        send_item(1'b0, HDR_FIRST);
        send_frame(8'h00, SAMPLE_MAX_RST, SAMPLE_MIN_RST, 1'b0, -1);
        send_item(1'b0, HDR_FIRST);
        send_item(1'b0, 8'h13);
        // link lost in the middle of a frame with a corrupt CRC
        send_frame(8'hFF, 16'sh8000, 16'sh7FFF, 1'b1, 4);
    endtask

    task automatic test_threshold_sweep();
        run_traffic(230);
        set_thresholds(16'h8000, 16'h7FFF, 16'h0000);
        run_traffic(230);
        set_thresholds(16'h8000, 16'h7FFF, 16'hFFFF);
        run_traffic(230);
        // inverted window: nothing passes the range check
        set_thresholds(16'(300), 16'(-300), 16'(1000));
        run_traffic(200);
        set_thresholds(16'($urandom), 16'($urandom), 16'($urandom));
        write_reg(CFG_UNUSED, 16'($urandom));
        run_traffic(200);
        set_thresholds(16'(1234), 16'(1234), 16'h0000);
        run_traffic(150);
        quiet = 1'b1;
        set_thresholds(SAMPLE_MIN_RST, SAMPLE_MAX_RST, STEP_LIMIT_RST);
        run_traffic(230);
        quiet = 1'b0;
    endtask

    task automatic test_flow_control();
        wait_drain();
        quiet = 1'b1;
        @(posedge clk);
        hold_cycles = 120;
        repeat (12) send_random_frame(1'b0);
        wait_drain();
        quiet = 1'b0;
        repeat (4) send_random_frame(1'b1);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall = 1'b1;
            hold_cycles--;
        end
        else
            out_stall = !quiet && ($urandom_range(0, 99) < 20);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d seq %h",
                         $time, status, sequence_res);
                mismatch_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                status_hits[want.status]++;
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    mismatch_count++;
                end
                if (sequence_res !== want.seq)
                begin
                    $display("%0t: sequence mismatch, expected %h, actual %h",
                             $time, want.seq, sequence_res);
                    mismatch_count++;
                end
                if (accel_sample !== want.accel)
                begin
                    $display("%0t: accel mismatch, expected %0d, actual %0d",
                             $time, want.accel, accel_sample);
                    mismatch_count++;
                end
                if (brake_sample !== want.brake)
                begin
                    $display("%0t: brake mismatch, expected %0d, actual %0d",
                             $time, want.brake, brake_sample);
                    mismatch_count++;
                end
            end
        end
    end

    // ends the run when neither channel has moved for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SAMPLE_MIN;
        cfg_data = 16'h0000;
        in_valid = 1'b0;
        op = 1'b0;
        byte_value = 8'h00;
        m_min = SAMPLE_MIN_RST;
        m_max = SAMPLE_MAX_RST;
        m_step = STEP_LIMIT_RST;
        m_pos = POS_HUNT;
        m_crc = 8'h00;
        m_bytes = '{default: 8'h00};
        m_last_accel = 16'sd0;
        m_last_brake = 16'sd0;
        m_hist = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_threshold_sweep();
        test_flow_control();

        wait_drain();
        repeat (10) @(negedge clk);
        if (expected_frames.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_frames.size());
            mismatch_count++;
        end
        $display("Sent %0d items; results ok %0d, crc %0d, range %0d, slew %0d",
                 items_sent, status_hits[ST_OK], status_hits[ST_CRC],
                 status_hits[ST_RANGE], status_hits[ST_SLEW]);
        $display("Seven threshold settings, header resync, link loss, result hold-off");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sfr_pkg.sv
hw/rtl/sensor_frame_receiver.sv
sim/sensor_frame_receiver_tb.sv
